/* rtl/core/border_connected_hole_fill_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for border_connected_hole_fill
// Clocked concurrent assertion wrappers, disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef BORDER_CONNECTED_HOLE_FILL_ASSERT_SVH
`define BORDER_CONNECTED_HOLE_FILL_ASSERT_SVH

// Same-cycle property, checked on every rising edge out of reset.
`define BCHF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define BCHF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/bchf_pkg.sv */
// ----------------------------------------------------------------------------
// bchf_pkg
// Shared constants, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package bchf_pkg;

  localparam int VALUE_W   = 16;
  localparam int DIM_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 2'd3;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  localparam logic [VALUE_W-1:0] FOREGROUND_RST = 16'd1;
  localparam logic [VALUE_W-1:0] BACKGROUND_RST = 16'd0;
  localparam logic [DIM_W-1:0]   WIDTH_RST      = 9'd256;
  localparam logic [DIM_W-1:0]   HEIGHT_RST     = 9'd256;

  typedef struct packed {
    logic load;        // store a loaded pixel, clear its reached bit
    logic from_zero;   // load restarts the slice at pixel 0
    logic fetch;       // read result at drain position, capture last flag
    logic pos_adv;
    logic pos_clr;
    logic flood_init;  // reset seed walk and stack
    logic vis_rd;      // read store at visit coordinate
    logic vis_ck;      // test read data, mark and push on a hit
    logic vis_nb;      // visit coordinate is a neighbor, not a seed
    logic seed_adv;
    logic pop;
    logic nb_clr;
    logic nb_adv;
    logic resp;        // register a drained result
    logic resp_nr;     // register a not-ready result
  } bchf_cmd_t;

  typedef struct packed {
    logic pos_last;
    logic one_pixel;
    logic seed_last;
    logic nb_ok;
    logic nb_last;
    logic stack_empty;
    logic dim_wr;
  } bchf_stat_t;

endpackage

`default_nettype wire

/* rtl/core/bchf_ctrl.sv */
// ----------------------------------------------------------------------------
// bchf_ctrl
// Sequencer for load, flood (seed walk and stack walk) and drain.
// ----------------------------------------------------------------------------
`default_nettype none

module bchf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  in_func,
  input  bchf_pkg::bchf_stat_t  stat,
  output bchf_pkg::bchf_cmd_t   cmd,
  output logic                  busy
);
  import bchf_pkg::*;

  typedef enum logic [7:0] {
    S_LOAD    = 8'b0000_0001,
    S_DRAIN   = 8'b0000_0010,
    S_RESP_L  = 8'b0000_0100,
    S_RESP_D  = 8'b0000_1000,
    S_SEED_RD = 8'b0001_0000,
    S_SEED_CK = 8'b0010_0000,
    S_POP     = 8'b0100_0000,
    S_NB_RD   = 8'b1000_0000
  } ctrl_state_t;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        accept;

  assign busy   = (state_r != S_LOAD) && (state_r != S_DRAIN);
  assign accept = start && !busy;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (in_func == FUNC_FETCH) begin
            cmd.resp_nr = 1'b1;
          end else begin
            cmd.load = 1'b1;
            if (stat.pos_last) begin
              cmd.pos_clr    = 1'b1;
              cmd.flood_init = 1'b1;
              state_nxt      = S_SEED_RD;
            end else begin
              cmd.pos_adv = 1'b1;
            end
          end
        end
      end
      S_DRAIN: begin
        priority if (accept && in_func == FUNC_FETCH) begin
          cmd.fetch = 1'b1;
          if (stat.pos_last) begin
            cmd.pos_clr = 1'b1;
            state_nxt   = S_RESP_L;
          end else begin
            cmd.pos_adv = 1'b1;
            state_nxt   = S_RESP_D;
          end
        end else if (accept) begin
          // abandon the pending slice, this beat is pixel 0 of a new one
          cmd.load      = 1'b1;
          cmd.from_zero = 1'b1;
          if (stat.one_pixel) begin
            cmd.pos_clr    = 1'b1;
            cmd.flood_init = 1'b1;
            state_nxt      = S_SEED_RD;
          end else begin
            cmd.pos_adv = 1'b1;
            state_nxt   = S_LOAD;
          end
        end else if (stat.dim_wr) begin
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_RESP_L: begin
        cmd.resp  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_RESP_D: begin
        cmd.resp  = 1'b1;
        state_nxt = S_DRAIN;
      end
      S_SEED_RD: begin
        cmd.vis_rd = 1'b1;
        state_nxt  = S_SEED_CK;
      end
      S_SEED_CK: begin
        cmd.vis_ck = 1'b1;
        if (stat.seed_last) begin
          state_nxt = S_POP;
        end else begin
          cmd.seed_adv = 1'b1;
          state_nxt    = S_SEED_RD;
        end
      end
      S_POP: begin
        if (stat.stack_empty) begin
          state_nxt = S_DRAIN;
        end else begin
          cmd.pop    = 1'b1;
          cmd.nb_clr = 1'b1;
          state_nxt  = S_NB_RD;
        end
      end
      S_NB_RD: begin
        cmd.vis_nb = 1'b1;
        if (stat.nb_ok) begin
          cmd.vis_rd = 1'b1;
          state_nxt  = S_SEED_CK;
        end else if (stat.nb_last) begin
          state_nxt = S_POP;
        end else begin
          cmd.nb_adv = 1'b1;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
    // neighbor check shares the check state with the seed walk
    if (state_r == S_SEED_CK && nb_phase_r) begin
      cmd          = '0;
      cmd.vis_nb   = 1'b1;
      cmd.vis_ck   = 1'b1;
      if (stat.nb_last) begin
        state_nxt = S_POP;
      end else begin
        cmd.nb_adv = 1'b1;
        state_nxt  = S_NB_RD;
      end
    end
  end

  // set while the check state serves the stack walk rather than the seed walk
  logic nb_phase_r;
  logic nb_phase_nxt;

  always_comb begin
    nb_phase_nxt = nb_phase_r;
    priority if (cmd.flood_init) begin
      nb_phase_nxt = 1'b0;
    end else if (state_r == S_POP) begin
      nb_phase_nxt = 1'b1;
    end else begin
      nb_phase_nxt = nb_phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      nb_phase_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      nb_phase_r <= nb_phase_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bchf_datapath.sv */
// ----------------------------------------------------------------------------
// bchf_datapath
// Configuration registers, pixel/reached store, work stack, walk counters
// and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module bchf_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bchf_pkg::bchf_cmd_t                 cmd,
  output bchf_pkg::bchf_stat_t                stat,
  input  logic [bchf_pkg::VALUE_W-1:0]        in_pixel_value,
  input  logic                                cfg_we,
  input  logic [bchf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bchf_pkg::VALUE_W-1:0]        cfg_wdata,
  output logic                                out_valid,
  output logic [bchf_pkg::VALUE_W-1:0]        out_filled_value,
  output logic                                out_is_last,
  output logic                                out_not_ready
);
  import bchf_pkg::*;

  localparam int XB    = $clog2(MAX_WIDTH);
  localparam int YB    = $clog2(MAX_HEIGHT);
  localparam int AB    = XB + YB;
  localparam int SB    = (XB > YB) ? XB : YB;
  localparam int SW    = (PIXEL_BITS < VALUE_W) ? PIXEL_BITS : VALUE_W;
  localparam int DEPTH = 1 << AB;

  localparam logic [1:0] SEED_TOP    = 2'd0;
  localparam logic [1:0] SEED_BOTTOM = 2'd1;
  localparam logic [1:0] SEED_LEFT   = 2'd2;
  localparam logic [1:0] SEED_RIGHT  = 2'd3;

  localparam logic [1:0] NB_UP    = 2'd0;
  localparam logic [1:0] NB_DOWN  = 2'd1;
  localparam logic [1:0] NB_LEFT  = 2'd2;
  localparam logic [1:0] NB_RIGHT = 2'd3;

  // configuration
  logic [VALUE_W-1:0] fg_r;
  logic [VALUE_W-1:0] bg_r;
  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  logic               dim_wr;
  logic [XB-1:0]      wm1;
  logic [YB-1:0]      hm1;

  assign dim_wr = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r     <= FOREGROUND_RST;
      bg_r     <= BACKGROUND_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FOREGROUND: fg_r     <= cfg_wdata;
        REG_BACKGROUND: bg_r     <= cfg_wdata;
        REG_WIDTH:      width_r  <= cfg_wdata[DIM_W-1:0];
        REG_HEIGHT:     height_r <= cfg_wdata[DIM_W-1:0];
      endcase
    end
  end

  // last column and row, zero acts as one, oversize saturates
  always_comb begin
    priority if (width_r == '0) begin
      wm1 = '0;
    end else if (32'(width_r) > MAX_WIDTH) begin
      wm1 = XB'(MAX_WIDTH - 1);
    end else begin
      wm1 = XB'(width_r - 1'b1);
    end
    priority if (height_r == '0) begin
      hm1 = '0;
    end else if (32'(height_r) > MAX_HEIGHT) begin
      hm1 = YB'(MAX_HEIGHT - 1);
    end else begin
      hm1 = YB'(height_r - 1'b1);
    end
  end

  // load / drain position
  logic [XB-1:0] px_r, px_nxt;
  logic [YB-1:0] py_r, py_nxt;
  logic [XB-1:0] base_x;
  logic [YB-1:0] base_y;

  assign base_x = cmd.from_zero ? '0 : px_r;
  assign base_y = cmd.from_zero ? '0 : py_r;

  always_comb begin
    priority if (dim_wr || cmd.pos_clr) begin
      px_nxt = '0;
      py_nxt = '0;
    end else if (cmd.pos_adv) begin
      if (base_x == wm1) begin
        px_nxt = '0;
        py_nxt = base_y + YB'(1);
      end else begin
        px_nxt = base_x + XB'(1);
        py_nxt = base_y;
      end
    end else begin
      px_nxt = px_r;
      py_nxt = py_r;
    end
  end

  // seed walk over the four borders
  logic [1:0]    pass_r, pass_nxt;
  logic [SB-1:0] si_r, si_nxt;
  logic          pass_end;
  logic [XB-1:0] sx;
  logic [YB-1:0] sy;

  assign pass_end = pass_r[1] ? (si_r == SB'(hm1)) : (si_r == SB'(wm1));

  always_comb begin
    unique case (pass_r)
      SEED_TOP: begin
        sx = si_r[XB-1:0];
        sy = '0;
      end
      SEED_BOTTOM: begin
        sx = si_r[XB-1:0];
        sy = hm1;
      end
      SEED_LEFT: begin
        sx = '0;
        sy = si_r[YB-1:0];
      end
      SEED_RIGHT: begin
        sx = wm1;
        sy = si_r[YB-1:0];
      end
    endcase
  end

  always_comb begin
    priority if (cmd.flood_init) begin
      pass_nxt = SEED_TOP;
      si_nxt   = '0;
    end else if (cmd.seed_adv && pass_end) begin
      pass_nxt = pass_r + 2'd1;
      si_nxt   = '0;
    end else if (cmd.seed_adv) begin
      pass_nxt = pass_r;
      si_nxt   = si_r + SB'(1);
    end else begin
      pass_nxt = pass_r;
      si_nxt   = si_r;
    end
  end

  // stack walk: current pixel and its four neighbors
  logic [AB-1:0] stk_rd_r;
  logic [XB-1:0] cx;
  logic [YB-1:0] cy;
  logic [1:0]    nb_r, nb_nxt;
  logic [XB-1:0] nx;
  logic [YB-1:0] ny;
  logic          nb_ok;

  assign cx = stk_rd_r[XB-1:0];
  assign cy = stk_rd_r[AB-1:XB];

  always_comb begin
    nx = cx;
    ny = cy;
    unique case (nb_r)
      NB_UP: begin
        nb_ok = (cy != '0);
        ny    = cy - YB'(1);
      end
      NB_DOWN: begin
        nb_ok = (cy != hm1);
        ny    = cy + YB'(1);
      end
      NB_LEFT: begin
        nb_ok = (cx != '0);
        nx    = cx - XB'(1);
      end
      NB_RIGHT: begin
        nb_ok = (cx != wm1);
        nx    = cx + XB'(1);
      end
    endcase
  end

  always_comb begin
    priority if (cmd.nb_clr) begin
      nb_nxt = NB_UP;
    end else if (cmd.nb_adv) begin
      nb_nxt = nb_r + 2'd1;
    end else begin
      nb_nxt = nb_r;
    end
  end

  // pixel store: {reached, pixel}, reached bit cleared as each pixel loads
  logic [SW:0]   pix_mem [DEPTH];
  logic [SW:0]   mem_rd_r;
  logic [AB-1:0] vaddr;
  logic          mem_re;
  logic [AB-1:0] mem_ra;
  logic          hit;
  logic          mem_we;
  logic [AB-1:0] mem_wa;
  logic [SW:0]   mem_wd;

  assign vaddr  = cmd.vis_nb ? {ny, nx} : {sy, sx};
  assign mem_re = cmd.vis_rd || cmd.fetch;
  assign mem_ra = cmd.vis_rd ? vaddr : {py_r, px_r};
  assign hit    = cmd.vis_ck && !mem_rd_r[SW] && (mem_rd_r[SW-1:0] == bg_r[SW-1:0]);
  assign mem_we = cmd.load || hit;
  assign mem_wa = cmd.load ? {base_y, base_x} : vaddr;
  assign mem_wd = cmd.load ? {1'b0, in_pixel_value[SW-1:0]} : {1'b1, mem_rd_r[SW-1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pix_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_r <= pix_mem[mem_ra];
    end
  end

  // work stack, a pixel is pushed when it is marked
  logic [AB-1:0] stk_mem [DEPTH];
  logic [AB:0]   sp_r, sp_nxt;
  logic [AB:0]   sp_dec;

  assign sp_dec = sp_r - 1'b1;

  always_comb begin
    priority if (cmd.flood_init || dim_wr) begin
      sp_nxt = '0;
    end else if (hit) begin
      sp_nxt = sp_r + 1'b1;
    end else if (cmd.pop) begin
      sp_nxt = sp_dec;
    end else begin
      sp_nxt = sp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      stk_mem[sp_r[AB-1:0]] <= vaddr;
    end
    if (cmd.pop) begin
      stk_rd_r <= stk_mem[sp_dec[AB-1:0]];
    end
  end

  // result register
  logic               last_r, last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_nr_r, out_nr_nxt;

  assign last_nxt      = cmd.fetch ? (px_r == wm1 && py_r == hm1) : last_r;
  assign out_valid_nxt = cmd.resp || cmd.resp_nr;

  always_comb begin
    priority if (cmd.resp) begin
      out_value_nxt = mem_rd_r[SW] ? bg_r : fg_r;
      out_last_nxt  = last_r;
      out_nr_nxt    = 1'b0;
    end else if (cmd.resp_nr) begin
      out_value_nxt = '0;
      out_last_nxt  = 1'b0;
      out_nr_nxt    = 1'b1;
    end else begin
      out_value_nxt = out_value_r;
      out_last_nxt  = out_last_r;
      out_nr_nxt    = out_nr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r        <= '0;
      py_r        <= '0;
      pass_r      <= SEED_TOP;
      si_r        <= '0;
      nb_r        <= NB_UP;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      px_r        <= px_nxt;
      py_r        <= py_nxt;
      pass_r      <= pass_nxt;
      si_r        <= si_nxt;
      nb_r        <= nb_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_nr_r    <= out_nr_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_filled_value = out_value_r;
  assign out_is_last      = out_last_r;
  assign out_not_ready    = out_nr_r;

  assign stat.pos_last    = (px_r == wm1) && (py_r == hm1);
  assign stat.one_pixel   = (wm1 == '0) && (hm1 == '0);
  assign stat.seed_last   = (pass_r == SEED_RIGHT) && pass_end;
  assign stat.nb_ok       = nb_ok;
  assign stat.nb_last     = (nb_r == NB_RIGHT);
  assign stat.stack_empty = (sp_r == '0);
  assign stat.dim_wr      = dim_wr;

endmodule

`default_nettype wire

/* rtl/core/border_connected_hole_fill.sv */
// ----------------------------------------------------------------------------
// border_connected_hole_fill: fills holes not 4-connected to the slice border
// Load takes a beat whenever the block is not busy. Fetch: the result strobe
// follows accept via the response state and result register; a not-ready result
// is strobed in the cycle after accept. The flood after the last load holds busy.
// Reset is synchronous; reached bits clear as pixels load, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module border_connected_hole_fill #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int PIXEL_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_func,
  input  logic [bchf_pkg::VALUE_W-1:0]   in_pixel_value,
  output logic                           out_valid,
  output logic [bchf_pkg::VALUE_W-1:0]   out_filled_value,
  output logic                           out_is_last,
  output logic                           out_not_ready,
  input  logic                           cfg_we,
  input  logic [bchf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bchf_pkg::VALUE_W-1:0]   cfg_wdata
);
  import bchf_pkg::*;

  bchf_cmd_t  cmd;
  bchf_stat_t stat;

  bchf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  bchf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_pixel_value   (in_pixel_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_filled_value (out_filled_value),
    .out_is_last      (out_is_last),
    .out_not_ready    (out_not_ready)
  );

endmodule

`default_nettype wire

/* rtl/core/bchf_checker.sv */
// ----------------------------------------------------------------------------
// bchf_checker
// Port-level timing checks for border_connected_hole_fill, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "border_connected_hole_fill_assert.svh"

module bchf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         in_func,
  input logic                         out_valid,
  input logic [bchf_pkg::VALUE_W-1:0] out_filled_value,
  input logic                         out_is_last,
  input logic                         out_not_ready
);

  logic fetch_acc;

  assign fetch_acc = start && !busy && in_func;

  // every result beat answers an earlier accepted fetch
  `BCHF_ASSERT(a_result_has_fetch, clk, rst_n, out_valid |-> ($past(fetch_acc) || $past(fetch_acc, 2)), "result beat without a fetch")

  // a not-ready beat carries zero payload and no last mark
  `BCHF_ASSERT(a_not_ready_payload, clk, rst_n, (out_valid && out_not_ready) |-> (out_filled_value == '0 && !out_is_last), "not-ready beat with payload")

  // a drained beat is issued from a busy response state
  `BCHF_ASSERT(a_drain_after_busy, clk, rst_n, (out_valid && !out_not_ready) |-> $past(busy), "drained beat without a busy cycle")

  // an accepted fetch is either answered or holds the block busy
  `BCHF_ASSERT_NEXT(a_fetch_progress, clk, rst_n, fetch_acc, out_valid || busy, "fetch neither answered nor in progress")

endmodule

bind border_connected_hole_fill bchf_checker u_bchf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_func          (in_func),
  .out_valid        (out_valid),
  .out_filled_value (out_filled_value),
  .out_is_last      (out_is_last),
  .out_not_ready    (out_not_ready)
);

`default_nettype wire
